// ===== rtl/core/first_fit_aligned_allocator_core_assert.svh =====
// Assertion macros used by the allocator core.
`ifndef FIRST_FIT_ALIGNED_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_ALIGNED_ALLOCATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FFA_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define FFA_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define FFA_ASSERT_IMPL(lbl, pre, post)
`define FFA_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/ffa_pkg.sv =====
package ffa_pkg;
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_BAD   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic {
		CFG_HEAP_BASE = 1'b0,
		CFG_HEAP_SIZE = 1'b1
	} cfg_index_t;

	localparam int unsigned HEAP_BYTES    = 4096;
	localparam int unsigned HEAP_SIZE_W   = 13;
	localparam int unsigned CFG_W         = 32;
	localparam int unsigned OFFSET_W      = 12;
	localparam int unsigned RESET_HEAP    = 4096;
	localparam logic [8:0]  MAX_WANTED    = 9'd255;
	localparam int unsigned MIN_SPAN      = 2;
endpackage

// ===== rtl/core/ffa_req_if.sv =====
interface ffa_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  req_size;
	logic [7:0]  req_align;
	logic [11:0] free_offset;

	modport source (output valid, action, req_size, req_align, free_offset, input ready);
	modport sink (input valid, action, req_size, req_align, free_offset, output ready);
endinterface

// ===== rtl/core/ffa_rsp_if.sv =====
interface ffa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [11:0] block_offset;

	modport source (output valid, status, block_offset, input ready);
	modport sink (input valid, status, block_offset, output ready);
endinterface

// ===== rtl/core/first_fit_aligned_allocator_core.sv =====
// Channel | Direction | Payload
// req     | in        | action, req_size, req_align, free_offset
// rsp     | out       | status, block_offset
// cfg     | in (write)| cfg_index selects heap_base or heap_size, cfg_wdata
// Allocate: spans are scanned in order, ffa_mod computes the alignment modulo, each block byte
// is visited for header and padding writes, and entries are shifted when a span is dropped.
// Free: header-memory bytes are walked back, spans are scanned, entries are shifted.
// The span memory and the header memory have registered reads.
// After reset or a heap_size write, state S_INIT rebuilds the first span before req.ready rises.
// A result waits in the output register while the next item is accepted.
`include "first_fit_aligned_allocator_core_assert.svh"
module first_fit_aligned_allocator_core #(
	parameter int unsigned MAX_SPANS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ffa_req_if.sink                     req,
	ffa_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [ffa_pkg::CFG_W-1:0]   cfg_wdata
);
	localparam int unsigned AW  = $clog2(ffa_pkg::HEAP_BYTES);
	localparam int unsigned LW  = AW + 1;
	localparam int unsigned EW  = LW + 9;
	localparam int unsigned SW  = $clog2(MAX_SPANS);
	localparam int unsigned CW  = SW + 1;
	localparam int unsigned SPW = 2 * LW;
	localparam int unsigned RESET_SIZE =
		(ffa_pkg::HEAP_BYTES < ffa_pkg::RESET_HEAP) ? ffa_pkg::HEAP_BYTES : ffa_pkg::RESET_HEAP;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_ARD, S_ACHK, S_AMOD, S_AZERO,
		S_FRD, S_FCHK, S_FSRD, S_FSCHK, S_FDEC,
		S_RM, S_RMW, S_IN, S_INW, S_DONE
	} state_t;

	state_t           state_q;
	logic [31:0]      hbase_q;
	logic [LW-1:0]    hsize_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    k_q;
	logic [7:0]       size_q;
	logic [7:0]       align_q;
	logic [8:0]       wanted_q;
	logic [7:0]       pad_q;
	logic [LW-1:0]    sp_s_q;
	logic [LW-1:0]    sp_l_q;
	logic [EW-1:0]    a_q;
	logic [AW-1:0]    pos_q;
	logic [LW-1:0]    fstart_q;
	logic [7:0]       fsize_q;
	logic [EW-1:0]    fend_q;
	logic             lo_hit_q, up_hit_q, ins_found_q;
	logic [CW-1:0]    lo_idx_q, up_idx_q, ins_idx_q;
	logic [LW-1:0]    lo_s_q, lo_l_q, up_l_q;
	ffa_pkg::status_t res_st_q;
	logic [11:0]      res_off_q;
	logic             rsp_valid_q;
	logic [1:0]       rsp_st_q;
	logic [11:0]      rsp_off_q;

	logic [SPW-1:0]   span_mem [MAX_SPANS];
	logic [7:0]       hdr_mem [ffa_pkg::HEAP_BYTES];
	logic             sm_we;
	logic [SW-1:0]    sm_wa, sm_ra;
	logic [SPW-1:0]   sm_wd, sm_rd;
	logic             hm_we;
	logic [AW-1:0]    hm_wa, hm_ra;
	logic [7:0]       hm_wd, hm_rd;

	logic             div_start, div_done;
	logic [7:0]       div_rem;
	logic [LW-1:0]    rd_s, rd_l;
	logic [EW-1:0]    rd_e;
	logic [8:0]       wanted_in;
	logic [31:0]      hsize_sat;

	// The modulo starts in the cycle the fitting span is read, so it takes the start from memory.
	ffa_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (hbase_q + 32'(rd_s)),
		.den    (align_q),
		.done   (div_done),
		.rem    (div_rem)
	);

	always_ff @(posedge clk) begin
		if (sm_we) begin
			span_mem[sm_wa] <= sm_wd;
		end
		sm_rd <= span_mem[sm_ra];
	end

	always_ff @(posedge clk) begin
		if (hm_we) begin
			hdr_mem[hm_wa] <= hm_wd;
		end
		hm_rd <= hdr_mem[hm_ra];
	end

	assign rd_s      = sm_rd[SPW-1:LW];
	assign rd_l      = sm_rd[LW-1:0];
	assign rd_e      = EW'(rd_s) + EW'(rd_l);
	assign wanted_in = {1'b0, req.req_size} + {1'b0, req.req_align};
	assign hsize_sat =
		(32'(cfg_wdata[ffa_pkg::HEAP_SIZE_W-1:0]) > 32'(ffa_pkg::HEAP_BYTES)) ?
		32'(ffa_pkg::HEAP_BYTES) : 32'(cfg_wdata[ffa_pkg::HEAP_SIZE_W-1:0]);

	// Memory access decode for the current step.
	always_comb begin
		sm_we     = 1'b0;
		sm_wa     = idx_q[SW-1:0];
		sm_wd     = '0;
		sm_ra     = idx_q[SW-1:0];
		hm_we     = 1'b0;
		hm_wa     = a_q[AW-1:0];
		hm_wd     = 8'd0;
		hm_ra     = pos_q;
		div_start = 1'b0;
		case (state_q)
			S_INIT: begin
				sm_we = 1'b1;
				sm_wa = '0;
				sm_wd = {LW'(0), hsize_q};
			end
			S_ACHK: begin
				if (EW'(rd_l) >= EW'(wanted_q)) begin
					div_start = 1'b1;
					hm_we     = 1'b1;
					hm_wa     = rd_s[AW-1:0];
					hm_wd     = wanted_q[7:0];
				end
			end
			S_AZERO: begin
				if (a_q < EW'(sp_s_q) + EW'(wanted_q)) begin
					hm_we = !(a_q >= EW'(sp_s_q) + EW'(pad_q) &&
						a_q < EW'(sp_s_q) + EW'(pad_q) + EW'(size_q));
				end else if (EW'(sp_l_q) - EW'(wanted_q) >= EW'(ffa_pkg::MIN_SPAN)) begin
					sm_we = 1'b1;
					sm_wd = {LW'(EW'(sp_s_q) + EW'(wanted_q)),
						LW'(EW'(sp_l_q) - EW'(wanted_q))};
				end
			end
			S_FDEC: begin
				if (lo_hit_q) begin
					sm_we = 1'b1;
					sm_wa = lo_idx_q[SW-1:0];
					sm_wd = {lo_s_q, LW'(EW'(lo_l_q) + EW'(fsize_q) +
						(up_hit_q ? EW'(up_l_q) : EW'(0)))};
				end else if (up_hit_q) begin
					sm_we = 1'b1;
					sm_wa = up_idx_q[SW-1:0];
					sm_wd = {fstart_q, LW'(EW'(up_l_q) + EW'(fsize_q))};
				end
			end
			S_RM: begin
				sm_ra = SW'(k_q + CW'(1));
			end
			S_RMW: begin
				sm_we = 1'b1;
				sm_wa = k_q[SW-1:0];
				sm_wd = sm_rd;
			end
			S_IN: begin
				sm_ra = SW'(k_q - CW'(1));
				if (k_q <= ins_idx_q) begin
					sm_we = 1'b1;
					sm_wa = ins_idx_q[SW-1:0];
					sm_wd = {fstart_q, LW'(fsize_q)};
				end
			end
			S_INW: begin
				sm_we = 1'b1;
				sm_wa = k_q[SW-1:0];
				sm_wd = sm_rd;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			hbase_q     <= '0;
			hsize_q     <= LW'(RESET_SIZE);
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == ffa_pkg::CFG_HEAP_BASE) begin
					hbase_q <= cfg_wdata;
				end else begin
					hsize_q <= LW'(hsize_sat);
					state_q <= S_INIT;
				end
			end else begin
				case (state_q)
					S_INIT: begin
						cnt_q   <= CW'(1);
						state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (req.valid) begin
							size_q    <= req.req_size;
							align_q   <= req.req_align;
							wanted_q  <= wanted_in;
							res_off_q <= '0;
							res_st_q  <= ffa_pkg::ST_BAD;
							idx_q     <= '0;
							pos_q     <= AW'(req.free_offset - 12'd1);
							state_q   <= S_DONE;
							if (!req.action) begin
								if (hsize_q != '0 && cnt_q != '0 && req.req_size != 8'd0 &&
									req.req_align != 8'd0 &&
									wanted_in < ffa_pkg::MAX_WANTED) begin
									state_q <= S_ARD;
								end
							end else if (hsize_q != '0 && req.free_offset != 12'd0 &&
								32'(req.free_offset) < 32'(hsize_q)) begin
								state_q <= S_FRD;
							end
						end
					end
					S_ARD: begin
						state_q <= S_ACHK;
					end
					S_ACHK: begin
						if (EW'(rd_l) >= EW'(wanted_q)) begin
							sp_s_q  <= rd_s;
							sp_l_q  <= rd_l;
							a_q     <= EW'(rd_s) + EW'(1);
							state_q <= S_AMOD;
						end else if (idx_q + CW'(1) >= cnt_q) begin
							res_st_q <= ffa_pkg::ST_NOFIT;
							state_q  <= S_DONE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_ARD;
						end
					end
					S_AMOD: begin
						if (div_done) begin
							pad_q   <= align_q - div_rem;
							state_q <= S_AZERO;
						end
					end
					S_AZERO: begin
						if (a_q < EW'(sp_s_q) + EW'(wanted_q)) begin
							a_q <= a_q + EW'(1);
						end else begin
							res_st_q  <= ffa_pkg::ST_OK;
							res_off_q <= 12'(EW'(sp_s_q) + EW'(pad_q));
							if (EW'(sp_l_q) - EW'(wanted_q) < EW'(ffa_pkg::MIN_SPAN)) begin
								k_q     <= idx_q;
								state_q <= S_RM;
							end else begin
								state_q <= S_DONE;
							end
						end
					end
					S_FRD: begin
						state_q <= S_FCHK;
					end
					S_FCHK: begin
						if (hm_rd == 8'd0) begin
							if (pos_q == '0) begin
								state_q <= S_DONE;
							end else begin
								pos_q   <= pos_q - AW'(1);
								state_q <= S_FRD;
							end
						end else if (EW'(pos_q) + EW'(hm_rd) > EW'(hsize_q)) begin
							state_q <= S_DONE;
						end else begin
							fstart_q    <= LW'(pos_q);
							fsize_q     <= hm_rd;
							fend_q      <= EW'(pos_q) + EW'(hm_rd);
							lo_hit_q    <= 1'b0;
							up_hit_q    <= 1'b0;
							ins_found_q <= 1'b0;
							ins_idx_q   <= cnt_q;
							state_q     <= (cnt_q == '0) ? S_FDEC : S_FSRD;
						end
					end
					S_FSRD: begin
						state_q <= S_FSCHK;
					end
					S_FSCHK: begin
						if (EW'(rd_s) < fend_q && EW'(fstart_q) < rd_e) begin
							state_q <= S_DONE;
						end else begin
							if (rd_e == EW'(fstart_q)) begin
								lo_hit_q <= 1'b1;
								lo_idx_q <= idx_q;
								lo_s_q   <= rd_s;
								lo_l_q   <= rd_l;
							end
							if (EW'(rd_s) == fend_q) begin
								up_hit_q <= 1'b1;
								up_idx_q <= idx_q;
								up_l_q   <= rd_l;
							end
							if (!ins_found_q && rd_s >= fstart_q) begin
								ins_found_q <= 1'b1;
								ins_idx_q   <= idx_q;
							end
							if (idx_q + CW'(1) >= cnt_q) begin
								state_q <= S_FDEC;
							end else begin
								idx_q   <= idx_q + CW'(1);
								state_q <= S_FSRD;
							end
						end
					end
					S_FDEC: begin
						res_st_q <= ffa_pkg::ST_OK;
						state_q  <= S_DONE;
						if (lo_hit_q && up_hit_q) begin
							// The merged upper span leaves the table.
							k_q     <= up_idx_q;
							state_q <= S_RM;
						end else if (!lo_hit_q && !up_hit_q) begin
							if (32'(cnt_q) >= 32'(MAX_SPANS)) begin
								res_st_q <= ffa_pkg::ST_FULL;
							end else begin
								k_q     <= cnt_q;
								state_q <= S_IN;
							end
						end
					end
					S_RM: begin
						if (k_q + CW'(1) < cnt_q) begin
							state_q <= S_RMW;
						end else begin
							cnt_q   <= cnt_q - CW'(1);
							state_q <= S_DONE;
						end
					end
					S_RMW: begin
						k_q     <= k_q + CW'(1);
						state_q <= S_RM;
					end
					S_IN: begin
						if (k_q > ins_idx_q) begin
							state_q <= S_INW;
						end else begin
							cnt_q   <= cnt_q + CW'(1);
							state_q <= S_DONE;
						end
					end
					S_INW: begin
						k_q     <= k_q - CW'(1);
						state_q <= S_IN;
					end
					S_DONE: begin
						if (!rsp_valid_q || rsp.ready) begin
							rsp_valid_q <= 1'b1;
							rsp_st_q    <= res_st_q;
							rsp_off_q   <= res_off_q;
							state_q     <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	// No item is taken in a cycle that writes a register.
	assign req.ready        = (state_q == S_IDLE) && !cfg_we;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_st_q;
	assign rsp.block_offset = rsp_off_q;

	`FFA_ASSERT_IMPL(a_cnt_bound, 1'b1, 32'(cnt_q) <= 32'(MAX_SPANS))
	`FFA_ASSERT_IMPL(a_div_owner, div_done, state_q == S_AMOD)
	`FFA_ASSERT_IMPL(a_hdr_in_heap, hm_we, EW'(hm_wa) < EW'(hsize_q))
	`FFA_ASSERT_IMPL(a_span_wr_idx, sm_we && state_q != S_INIT, CW'(sm_wa) <= cnt_q)
endmodule

// ===== rtl/core/ffa_mod.sv =====
module ffa_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [7:0]  den,
	output logic        done,
	output logic [7:0]  rem
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  bit_q;
	logic [31:0] num_q;
	logic [7:0]  den_q;
	logic [7:0]  rem_q;
	logic [8:0]  trial;

	// One quotient bit per cycle; the partial remainder always stays below den.
	always_comb begin
		trial = {rem_q, num_q[31]};
		if (trial >= {1'b0, den_q}) begin
			trial = trial - {1'b0, den_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + 5'd1;
				if (bit_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= trial[7:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// ===== bench/first_fit_aligned_allocator_core_tb.sv =====
module first_fit_aligned_allocator_core_tb;
	localparam int unsigned HEAP_LIMIT = ffa_pkg::HEAP_BYTES;
	localparam int unsigned SPAN_SLOTS = 16;
	localparam int unsigned SETTLE_CYCLES = 800;

	typedef struct packed {
		logic        action;
		logic [7:0]  req_size;
		logic [7:0]  req_align;
		logic [11:0] free_offset;
	} alloc_req_t;

	typedef struct packed {
		ffa_pkg::status_t status;
		logic [11:0]      block_offset;
	} alloc_rsp_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [ffa_pkg::CFG_W-1:0] cfg_wdata;

	ffa_req_if req_ch();
	ffa_rsp_if rsp_ch();

	first_fit_aligned_allocator_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Predicted allocator state.
	logic [31:0] base_addr;
	logic [12:0] heap_len;
	logic [12:0] span_st [SPAN_SLOTS];
	logic [12:0] span_ln [SPAN_SLOTS];
	int unsigned span_cnt;
	logic [7:0] hdr_mem [HEAP_LIMIT];
	bit hdr_seen [HEAP_LIMIT];

	alloc_req_t pending_reqs[$];
	alloc_rsp_t awaited_rsps[$];
	logic [11:0] live_blocks[$];
	logic [11:0] freed_blocks[$];

	bit failed;
	bit req_fire;
	bit no_gaps;
	bit hold_rsp;
	int unsigned send_gap;
	int unsigned stall_left;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void restart_table();
		span_st[0] = '0;
		span_ln[0] = heap_len;
		span_cnt = 1;
	endfunction

	function automatic void drop_span(int unsigned idx);
		for (int unsigned k = idx; k + 1 < span_cnt; k++) begin
			span_st[k] = span_st[k + 1];
			span_ln[k] = span_ln[k + 1];
		end
		if (span_cnt > 0) span_cnt--;
	endfunction

	function automatic void put_hdr(int unsigned a, logic [7:0] v);
		if (a < HEAP_LIMIT) begin
			hdr_mem[a] = v;
			hdr_seen[a] = 1'b1;
		end
	endfunction

	// A free is only legal when its walk back never touches a byte that was never written.
	function automatic bit walk_is_defined(logic [11:0] fo);
		int unsigned pos;
		if (heap_len == 0 || fo == 0 || fo >= heap_len) return 1'b1;
		pos = fo - 1;
		forever begin
			if (!hdr_seen[pos]) return 1'b0;
			if (hdr_mem[pos] != 0 || pos == 0) return 1'b1;
			pos--;
		end
	endfunction

	function automatic ffa_pkg::status_t carve_block(int unsigned sz, int unsigned al,
			output logic [11:0] off);
		int unsigned wanted;
		int unsigned s;
		int unsigned pad;
		logic [31:0] addr;
		wanted = sz + al;
		off = '0;
		if (heap_len == 0 || span_cnt == 0 || sz == 0 || al == 0 ||
			wanted >= ffa_pkg::MAX_WANTED)
			return ffa_pkg::ST_BAD;
		for (int unsigned i = 0; i < span_cnt; i++) begin
			if (span_ln[i] < wanted) continue;
			s = span_st[i];
			put_hdr(s, wanted[7:0]);
			addr = base_addr + s;
			pad = al - (addr % al);
			for (int unsigned a = s + 1; a < s + pad; a++) put_hdr(a, 8'h00);
			for (int unsigned a = s + pad + sz; a < s + wanted; a++) put_hdr(a, 8'h00);
			span_st[i] = 13'(s + wanted);
			span_ln[i] = 13'(span_ln[i] - wanted);
			if (span_ln[i] < ffa_pkg::MIN_SPAN) drop_span(i);
			off = 12'(s + pad);
			return ffa_pkg::ST_OK;
		end
		return ffa_pkg::ST_NOFIT;
	endfunction

	function automatic ffa_pkg::status_t release_block(logic [11:0] fo);
		int unsigned pos;
		int unsigned bstart;
		int unsigned bsize;
		int unsigned bend;
		int unsigned lo_idx;
		int unsigned hi_idx;
		int unsigned s;
		int unsigned e;
		int unsigned at;
		bit has_lo;
		bit has_hi;
		has_lo = 0;
		has_hi = 0;
		lo_idx = 0;
		hi_idx = 0;
		if (heap_len == 0 || fo == 0 || fo >= heap_len) return ffa_pkg::ST_BAD;
		pos = fo - 1;
		while (hdr_mem[pos] == 0) begin
			if (pos == 0) return ffa_pkg::ST_BAD;
			pos--;
		end
		bstart = pos;
		bsize = hdr_mem[pos];
		bend = bstart + bsize;
		if (bend > heap_len) return ffa_pkg::ST_BAD;
		for (int unsigned i = 0; i < span_cnt; i++) begin
			s = span_st[i];
			e = span_st[i] + span_ln[i];
			if (s < bend && bstart < e) return ffa_pkg::ST_BAD;
			if (e == bstart) begin
				has_lo = 1;
				lo_idx = i;
			end
			if (s == bend) begin
				has_hi = 1;
				hi_idx = i;
			end
		end
		if (has_lo && has_hi) begin
			span_ln[lo_idx] = 13'(span_ln[lo_idx] + bsize + span_ln[hi_idx]);
			drop_span(hi_idx);
		end else if (has_lo) begin
			span_ln[lo_idx] = 13'(span_ln[lo_idx] + bsize);
		end else if (has_hi) begin
			span_st[hi_idx] = 13'(bstart);
			span_ln[hi_idx] = 13'(span_ln[hi_idx] + bsize);
		end else begin
			if (span_cnt >= SPAN_SLOTS) return ffa_pkg::ST_FULL;
			at = span_cnt;
			for (int unsigned i = 0; i < span_cnt; i++) begin
				if (span_st[i] >= bstart) begin
					at = i;
					break;
				end
			end
			for (int unsigned k = span_cnt; k > at; k--) begin
				span_st[k] = span_st[k - 1];
				span_ln[k] = span_ln[k - 1];
			end
			span_st[at] = 13'(bstart);
			span_ln[at] = 13'(bsize);
			span_cnt++;
		end
		return ffa_pkg::ST_OK;
	endfunction

	// Predicts the result and queues the item; frees that would walk into unwritten
	// header bytes are dropped here and never sent.
	task automatic issue(logic act, logic [7:0] sz, logic [7:0] al, logic [11:0] fo);
		alloc_req_t item;
		alloc_rsp_t res;
		logic [11:0] off;
		if (act && !walk_is_defined(fo)) return;
		item = '{action: act, req_size: sz, req_align: al, free_offset: fo};
		if (!act) begin
			res.status = carve_block(sz, al, off);
			res.block_offset = off;
			if (res.status == ffa_pkg::ST_OK) live_blocks = {live_blocks, off};
		end else begin
			res.status = release_block(fo);
			res.block_offset = '0;
		end
		pending_reqs = {pending_reqs, item};
		awaited_rsps = {awaited_rsps, res};
	endtask

	task automatic free_live();
		int unsigned k;
		logic [11:0] off;
		if (live_blocks.size() == 0) return;
		k = $urandom_range(0, live_blocks.size() - 1);
		off = live_blocks[k];
		live_blocks.delete(k);
		freed_blocks = {freed_blocks, off};
		if (freed_blocks.size() > 8) void'(freed_blocks.pop_front());
		issue(1'b1, 8'd0, 8'd0, off);
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0 && awaited_rsps.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(ffa_pkg::cfg_index_t idx, logic [31:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == ffa_pkg::CFG_HEAP_BASE) begin
			base_addr = v;
		end else begin
			heap_len = (v[12:0] > HEAP_LIMIT) ? 13'(HEAP_LIMIT) : v[12:0];
			restart_table();
			live_blocks.delete();
			freed_blocks.delete();
		end
	endtask

	task automatic random_alloc();
		int unsigned r;
		logic [7:0] al;
		logic [7:0] sz;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			issue(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 12'($urandom));
			return;
		end
		if (r < 50) al = 8'(1 << $urandom_range(0, 7));
		else if (r < 90) al = 8'($urandom_range(1, 12));
		else al = 8'($urandom_range(1, 253));
		if (al < 254 && $urandom_range(0, 9) == 0) sz = 8'($urandom_range(1, 254 - al));
		else sz = 8'($urandom_range(1, (254 - al < 16) ? 254 - al : 16));
		issue(1'b0, sz, al, 12'($urandom));
	endtask

	task automatic random_phase(int unsigned n);
		int unsigned r;
		for (int unsigned i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 50) random_alloc();
			else if (r < 84) free_live();
			else if (r < 92 && freed_blocks.size() > 0)
				issue(1'b1, 8'($urandom), 8'($urandom),
					freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
			else issue(1'b1, 8'($urandom), 8'($urandom), 12'($urandom));
		end
	endtask

	// Sender: holds an item until it is taken, then waits a random gap (none when no_gaps is set).
	always @(posedge clk) req_fire <= req_ch.valid && req_ch.ready;

	always @(negedge clk) begin
		if (arst_n && (!req_ch.valid || req_fire)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				req_ch.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				{req_ch.action, req_ch.req_size, req_ch.req_align, req_ch.free_offset}
					<= pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
				send_gap <= no_gaps ? 0 : pick_gap();
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls unless no_gaps is set, plus one long hold-off when requested.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (hold_rsp) begin
			hold_rsp <= 1'b0;
			stall_left <= 400;
			rsp_ch.ready <= 1'b0;
		end else if (no_gaps) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			stall_left <= pick_gap();
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		alloc_rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_rsps.size() == 0) begin
				$error("result with nothing expected: status %0d offset %0d",
					rsp_ch.status, rsp_ch.block_offset);
				failed = 1'b1;
			end else begin
				want = awaited_rsps.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, rsp_ch.status);
					failed = 1'b1;
				end
				if (rsp_ch.block_offset !== want.block_offset) begin
					$error("block_offset expected %0d actual %0d",
						want.block_offset, rsp_ch.block_offset);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#250000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		failed = 1'b0;
		no_gaps = 1'b0;
		hold_rsp = 1'b0;
		send_gap = 0;
		stall_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ffa_pkg::CFG_HEAP_BASE;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.action = 1'b0;
		req_ch.req_size = '0;
		req_ch.req_align = '0;
		req_ch.free_offset = '0;
		rsp_ch.ready = 1'b0;
		base_addr = '0;
		heap_len = 13'(ffa_pkg::RESET_HEAP);
		restart_table();
		for (int unsigned i = 0; i < HEAP_LIMIT; i++) begin
			hdr_mem[i] = '0;
			hdr_seen[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Malformed allocates, the largest legal total, and basic frees.
		issue(1'b0, 8'd0, 8'd4, 12'd0);
		issue(1'b0, 8'd4, 8'd0, 12'd0);
		issue(1'b0, 8'd200, 8'd60, 12'd0);
		issue(1'b0, 8'd255, 8'd255, 12'hfff);
		issue(1'b0, 8'd253, 8'd1, 12'd0);
		issue(1'b0, 8'd1, 8'd255 - 8'd2, 12'd0);
		issue(1'b0, 8'd3, 8'd8, 12'd0);
		issue(1'b1, 8'd0, 8'd0, 12'd0);
		issue(1'b1, 8'hff, 8'hff, 12'hfff);
		free_live();
		free_live();
		issue(1'b1, 8'd0, 8'd0, freed_blocks[0]);
		free_live();
		drain();

		// Wrapping alignment sum, then an invalid heap, a saturated heap and a tiny heap.
		write_reg(ffa_pkg::CFG_HEAP_BASE, 32'hffff_ffff);
		issue(1'b0, 8'd5, 8'd16, 12'd0);
		issue(1'b0, 8'd2, 8'd7, 12'd0);
		write_reg(ffa_pkg::CFG_HEAP_SIZE, 32'd0);
		issue(1'b0, 8'd1, 8'd1, 12'd0);
		issue(1'b1, 8'd0, 8'd0, 12'd5);
		write_reg(ffa_pkg::CFG_HEAP_SIZE, 32'h1fff);
		issue(1'b0, 8'd1, 8'd1, 12'd0);
		write_reg(ffa_pkg::CFG_HEAP_SIZE, 32'd13);
		issue(1'b0, 8'd10, 8'd4, 12'd0);
		issue(1'b0, 8'd8, 8'd4, 12'd0);
		issue(1'b0, 8'd1, 8'd1, 12'd0);
		free_live();

		// Fill the span table: a row of small blocks freed at every other position.
		write_reg(ffa_pkg::CFG_HEAP_BASE, 32'd0);
		write_reg(ffa_pkg::CFG_HEAP_SIZE, 32'd4096);
		for (int i = 0; i < 40; i++) issue(1'b0, 8'd1, 8'd1, 12'd0);
		for (int i = 0; i < 40; i += 2) issue(1'b1, 8'd0, 8'd0, 12'(2 * i + 1));
		for (int i = 1; i < 40; i += 2) issue(1'b1, 8'd0, 8'd0, 12'(2 * i + 1));
		drain();

		// The receiver holds off while the sender keeps offering items.
		hold_rsp = 1'b1;
		random_phase(60);
		drain();

		no_gaps = 1'b1;
		random_phase(250);
		drain();
		no_gaps = 1'b0;
		random_phase(250);
		write_reg(ffa_pkg::CFG_HEAP_BASE, $urandom);
		random_phase(250);
		write_reg(ffa_pkg::CFG_HEAP_SIZE, $urandom_range(64, 600));
		random_phase(250);
		write_reg(ffa_pkg::CFG_HEAP_BASE, 32'h0000_0003);
		write_reg(ffa_pkg::CFG_HEAP_SIZE, 32'd4096);
		random_phase(250);
		write_reg(ffa_pkg::CFG_HEAP_SIZE, $urandom_range(1, 8191));
		random_phase(250);

		wait (pending_reqs.size() == 0 && awaited_rsps.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (!failed) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

// ===== first_fit_aligned_allocator_core.f =====
+incdir+rtl/core
rtl/core/ffa_pkg.sv
rtl/core/ffa_req_if.sv
rtl/core/ffa_rsp_if.sv
rtl/core/ffa_mod.sv
rtl/core/first_fit_aligned_allocator_core.sv
bench/first_fit_aligned_allocator_core_tb.sv
